[hw/rtl/seven_segment_lcd_frame_builder_macros.svh]
// assertion macros for the frame builder
`ifndef SEVEN_SEGMENT_LCD_FRAME_BUILDER_MACROS_SVH
`define SEVEN_SEGMENT_LCD_FRAME_BUILDER_MACROS_SVH

// same-cycle implication
`define SSL_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("frame builder check failed");

// next-cycle implication
`define SSL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("frame builder check failed");

`endif

[hw/rtl/ssl_pkg.sv]
`default_nettype none

package ssl_pkg;

  typedef enum logic [3:0] {
    KIND_CHAR      = 4'd0,
    KIND_RAW       = 4'd1,
    KIND_STRING    = 4'd2,
    KIND_DECIMAL   = 4'd3,
    KIND_CLEAR     = 4'd4,
    KIND_BLINK_OFF = 4'd5,
    KIND_BLINK_ON  = 4'd6,
    KIND_REFRESH   = 4'd7,
    KIND_INIT      = 4'd8
  } kind_e;

  typedef enum logic {
    FRONT_IDLE,
    FRONT_DEC
  } front_state_e;

  localparam int unsigned FRAME_LEN = 10;
  localparam int unsigned NUM_DIGITS = 4;
  localparam int unsigned FONT_DEPTH = 40;

  localparam logic [5:0] FONT_DIGIT0 = 6'd0;
  localparam logic [5:0] FONT_DASH = 6'd10;
  localparam logic [5:0] FONT_UNDERSCORE = 6'd11;
  localparam logic [5:0] FONT_BLANK = 6'd12;
  localparam logic [5:0] FONT_LETTER_A = 6'd13;
  localparam logic [5:0] FONT_DEGREE = 6'd39;

  localparam logic [7:0] FONT_ROM [FONT_DEPTH] = '{
    8'h6F, 8'h03, 8'h5D, 8'h57, 8'h33, 8'h76, 8'h7E, 8'h43, 8'h7F, 8'h77,
    8'h10, 8'h04, 8'h00,
    8'h7B, 8'h3E, 8'h6C, 8'h1F, 8'h7C, 8'h78, 8'h6E, 8'h3A, 8'h03, 8'h0F,
    8'h3B, 8'h2C, 8'h5A, 8'h1A, 8'h6F, 8'h79, 8'h73, 8'h18, 8'h76, 8'h3C,
    8'h0E, 8'h2F, 8'h35, 8'h2B, 8'h37, 8'h5D,
    8'h01
  };

  localparam logic [7:0] INIT_FRAME [FRAME_LEN] = '{
    8'hCD, 8'h80, 8'hE0, 8'hF8, 8'h70, 8'h05, 8'hD5, 8'h9B, 8'hFF, 8'h00
  };

  localparam logic [7:0] CMD_MODE = 8'hCD;
  localparam logic [7:0] CMD_POINTER = 8'h80;
  localparam logic [7:0] CMD_DEVICE = 8'hE0;
  localparam logic [7:0] CMD_BANK = 8'hF8;
  localparam logic [7:0] CMD_NO_BLINK = 8'h70;
  localparam logic [7:0] CMD_FLASH = 8'h71;

  localparam logic [13:0] DEC_MAX = 14'd9999;
  localparam logic [13:0] DEC_MIN_MAG = 14'd999;
  localparam logic [15:0] RECIP_TEN = 16'hCCCD;
  localparam int unsigned RECIP_SHIFT = 19;

  typedef struct packed {
    logic            is_init;
    logic            bus;
    logic            blink;
    logic [3:0][7:0] codes;
  } job_t;

  typedef struct packed {
    logic valid;
    logic full;
  } queue_status_t;

  function automatic logic [7:0] font_lookup(input logic [7:0] c);
    logic [5:0] idx;
    idx = FONT_BLANK;
    if (c >= 8'h61 && c <= 8'h7A) begin
      idx = FONT_LETTER_A + 6'(c - 8'h61);
    end else if (c >= 8'h41 && c <= 8'h5A) begin
      idx = FONT_LETTER_A + 6'(c - 8'h41);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      idx = FONT_DIGIT0 + 6'(c - 8'h30);
    end else if (c == 8'h2D) begin
      idx = FONT_DASH;
    end else if (c == 8'h5F) begin
      idx = FONT_UNDERSCORE;
    end else if (c == 8'h2A) begin
      idx = FONT_DEGREE;
    end
    return FONT_ROM[idx];
  endfunction

endpackage

`default_nettype wire

[hw/rtl/ssl_if.sv]
`default_nettype none

interface ssl_item_if;
  logic               valid;
  logic               ready;
  logic [3:0]         kind;
  logic [1:0]         position;
  logic [7:0]         char_first;
  logic [7:0]         char_second;
  logic [7:0]         char_third;
  logic [7:0]         char_fourth;
  logic signed [15:0] dec_value;
  logic               timed;
  logic               display_select;

  modport source (
    output valid, kind, position, char_first, char_second, char_third, char_fourth,
           dec_value, timed, display_select,
    input  ready
  );
  modport sink (
    input  valid, kind, position, char_first, char_second, char_third, char_fourth,
           dec_value, timed, display_select,
    output ready
  );
endinterface

interface ssl_beat_if;
  logic       valid;
  logic       ready;
  logic       bus_select;
  logic       frame_start;
  logic [7:0] frame_byte;
  logic       frame_end;
  logic       last;

  modport source (
    output valid, bus_select, frame_start, frame_byte, frame_end, last,
    input  ready
  );
  modport sink (
    input  valid, bus_select, frame_start, frame_byte, frame_end, last,
    output ready
  );
endinterface

`default_nettype wire

[hw/rtl/ssl_front.sv]
`default_nettype none

module ssl_front #(
  parameter int unsigned HOLD_CYCLES = 8
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  ssl_item_if.sink                   item_i,
  input  wire ssl_pkg::queue_status_t q_status_i,
  output      logic                  push_o,
  output      ssl_pkg::job_t         push_job_o
);

  localparam logic [3:0] HoldLoad = 4'(HOLD_CYCLES);

  ssl_pkg::front_state_e state_q, state_d;
  logic [3:0][7:0] codes_q, codes_d;
  logic            blink_q, blink_d;
  logic [3:0]      hold_q, hold_d;
  logic [13:0]     mag_q, mag_d;
  logic [1:0]      digit_q, digit_d;
  logic            neg_q, neg_d;
  logic            bus_q, bus_d;

  logic            accept;
  logic            dec_start;
  logic            dec_done;
  logic            do_refresh;
  logic            do_init;
  logic            load_hold;
  logic            stop;
  logic [7:0]      chars [ssl_pkg::NUM_DIGITS];
  logic [15:0]     neg_value;
  logic [29:0]     prod;
  logic [13:0]     quot;
  logic [13:0]     rem;

  assign item_i.ready = (state_q == ssl_pkg::FRONT_IDLE) && !q_status_i.full;
  assign accept = item_i.valid && item_i.ready;
  assign dec_start = accept && (item_i.kind == ssl_pkg::KIND_DECIMAL);

  // one decimal digit per cycle through a reciprocal multiply
  assign prod = mag_q * ssl_pkg::RECIP_TEN;
  assign quot = 14'(prod[29:ssl_pkg::RECIP_SHIFT]);
  assign rem = mag_q - ((quot << 3) + (quot << 1));
  assign dec_done = (state_q == ssl_pkg::FRONT_DEC) && ((quot == '0) || (digit_q == '0));
  assign neg_value = 16'(-item_i.dec_value);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ssl_pkg::FRONT_IDLE: begin
        if (dec_start) state_d = ssl_pkg::FRONT_DEC;
      end
      ssl_pkg::FRONT_DEC: begin
        if (dec_done) state_d = ssl_pkg::FRONT_IDLE;
      end
      default: state_d = ssl_pkg::FRONT_IDLE;
    endcase
  end

  always_comb begin
    codes_d = codes_q;
    blink_d = blink_q;
    hold_d = hold_q;
    mag_d = mag_q;
    digit_d = digit_q;
    neg_d = neg_q;
    bus_d = bus_q;
    do_refresh = 1'b0;
    do_init = 1'b0;
    load_hold = 1'b0;
    stop = 1'b0;
    chars[0] = item_i.char_first;
    chars[1] = item_i.char_second;
    chars[2] = item_i.char_third;
    chars[3] = item_i.char_fourth;

    if (accept) begin
      unique case (ssl_pkg::kind_e'(item_i.kind))
        ssl_pkg::KIND_CHAR: begin
          codes_d[item_i.position] = ssl_pkg::font_lookup(item_i.char_first);
          do_refresh = 1'b1;
        end
        ssl_pkg::KIND_RAW: begin
          codes_d[item_i.position] = item_i.char_first;
          do_refresh = 1'b1;
        end
        ssl_pkg::KIND_STRING: begin
          codes_d = '0;
          for (int i = 0; i < ssl_pkg::NUM_DIGITS; i++) begin
            if (chars[i] == 8'h00) stop = 1'b1;
            if (!stop) codes_d[i] = ssl_pkg::font_lookup(chars[i]);
          end
          do_refresh = 1'b1;
          load_hold = item_i.timed;
        end
        ssl_pkg::KIND_DECIMAL: begin
          codes_d = '0;
          digit_d = 2'd3;
          bus_d = item_i.display_select;
          if (item_i.dec_value < -16'sd999) begin
            neg_d = 1'b1;
            mag_d = ssl_pkg::DEC_MIN_MAG;
          end else if (item_i.dec_value > 16'sd9999) begin
            neg_d = 1'b0;
            mag_d = ssl_pkg::DEC_MAX;
          end else if (item_i.dec_value < 16'sd0) begin
            neg_d = 1'b1;
            mag_d = neg_value[13:0];
          end else begin
            neg_d = 1'b0;
            mag_d = item_i.dec_value[13:0];
          end
        end
        ssl_pkg::KIND_CLEAR: begin
          codes_d = '0;
          do_refresh = 1'b1;
        end
        ssl_pkg::KIND_BLINK_OFF: begin
          blink_d = 1'b0;
          do_refresh = 1'b1;
        end
        ssl_pkg::KIND_BLINK_ON: begin
          blink_d = 1'b1;
          do_refresh = 1'b1;
        end
        ssl_pkg::KIND_REFRESH: begin
          do_refresh = 1'b1;
        end
        ssl_pkg::KIND_INIT: begin
          codes_d = '0;
          blink_d = 1'b0;
          do_init = 1'b1;
        end
        default: begin
        end
      endcase
    end

    if (state_q == ssl_pkg::FRONT_DEC) begin
      codes_d[digit_q] = ssl_pkg::FONT_ROM[6'(rem[3:0])];
      mag_d = quot;
      digit_d = digit_q - 2'd1;
      if (dec_done) begin
        do_refresh = 1'b1;
        if (neg_q && (quot == '0) && (digit_q != '0)) begin
          codes_d[digit_q - 2'd1] = ssl_pkg::FONT_ROM[ssl_pkg::FONT_DASH];
        end
      end
    end

    push_o = do_init;
    if (do_refresh) begin
      if (hold_q != '0) hold_d = hold_q - 4'd1;
      else push_o = 1'b1;
    end
    if (load_hold) hold_d = HoldLoad;
    if (do_init) hold_d = '0;

    push_job_o.is_init = do_init;
    push_job_o.bus = (state_q == ssl_pkg::FRONT_DEC) ? bus_q : item_i.display_select;
    push_job_o.blink = blink_d;
    push_job_o.codes = codes_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ssl_pkg::FRONT_IDLE;
      codes_q <= '0;
      blink_q <= 1'b0;
      hold_q <= '0;
    end else begin
      state_q <= state_d;
      codes_q <= codes_d;
      blink_q <= blink_d;
      hold_q <= hold_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
    digit_q <= digit_d;
    neg_q <= neg_d;
    bus_q <= bus_d;
  end

endmodule

`default_nettype wire

[hw/rtl/ssl_queue.sv]
`default_nettype none

module ssl_queue (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  push_i,
  input  wire ssl_pkg::job_t         push_job_i,
  input  wire logic                  pop_i,
  output      ssl_pkg::job_t         pop_job_o,
  output      ssl_pkg::queue_status_t status_o
);

  localparam int unsigned Depth = 2;

  ssl_pkg::job_t entries_q [Depth];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       do_push;
  logic       do_pop;

  assign status_o.valid = (count_q != '0);
  assign status_o.full = (count_q == 2'(Depth));
  assign do_push = push_i && !status_o.full;
  assign do_pop = pop_i && status_o.valid;
  assign pop_job_o = entries_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? !rd_ptr_q : rd_ptr_q;
    count_d = count_q + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) entries_q[wr_ptr_q] <= push_job_i;
  end

endmodule

`default_nettype wire

[hw/rtl/ssl_back.sv]
`default_nettype none

module ssl_back (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire ssl_pkg::queue_status_t q_status_i,
  input  wire ssl_pkg::job_t         q_job_i,
  output      logic                  pop_o,
  ssl_beat_if.source                 beat_o
);

  localparam logic [4:0] RefreshLast = 5'(ssl_pkg::FRAME_LEN - 1);
  localparam logic [4:0] InitLast = 5'(2 * ssl_pkg::FRAME_LEN - 1);
  localparam logic [4:0] FrameLen = 5'(ssl_pkg::FRAME_LEN);
  localparam logic [3:0] PosLast = 4'(ssl_pkg::FRAME_LEN - 1);

  ssl_pkg::job_t job_q, job_d;
  logic       active_q, active_d;
  logic [4:0] cnt_q, cnt_d;
  logic       out_valid_q, out_valid_d;
  logic       bus_q, start_q, end_q, last_q;
  logic [7:0] byte_q;

  logic       fire;
  logic       done;
  logic [4:0] last_idx;
  logic [3:0] pos;
  logic       bus;
  logic [7:0] byte_val;
  logic [7:0] c0, c1, c2, c3;

  assign c0 = job_q.codes[0];
  assign c1 = job_q.codes[1];
  assign c2 = job_q.codes[2];
  assign c3 = job_q.codes[3];

  assign last_idx = job_q.is_init ? InitLast : RefreshLast;
  assign fire = active_q && (!out_valid_q || beat_o.ready);
  assign done = fire && (cnt_q == last_idx);
  assign pop_o = q_status_i.valid && (!active_q || done);

  always_comb begin
    if (job_q.is_init && (cnt_q >= FrameLen)) begin
      pos = 4'(cnt_q - FrameLen);
      bus = 1'b1;
    end else begin
      pos = cnt_q[3:0];
      bus = job_q.is_init ? 1'b0 : job_q.bus;
    end
  end

  // 28 bits of segment data packed behind five command beats
  always_comb begin
    unique case (pos)
      4'd0: byte_val = ssl_pkg::CMD_MODE;
      4'd1: byte_val = ssl_pkg::CMD_POINTER;
      4'd2: byte_val = ssl_pkg::CMD_DEVICE;
      4'd3: byte_val = ssl_pkg::CMD_BANK;
      4'd4: byte_val = job_q.blink ? ssl_pkg::CMD_FLASH : ssl_pkg::CMD_NO_BLINK;
      4'd5: byte_val = c0 >> 4;
      4'd6: byte_val = (c0 << 4) | (c1 >> 3);
      4'd7: byte_val = (c1 << 5) | (c2 >> 2);
      4'd8: byte_val = (c2 << 6) | (c3 >> 1);
      4'd9: byte_val = c3 << 7;
      default: byte_val = 8'h00;
    endcase
    if (job_q.is_init && (pos <= PosLast)) byte_val = ssl_pkg::INIT_FRAME[pos];
  end

  always_comb begin
    active_d = active_q;
    cnt_d = cnt_q;
    job_d = job_q;
    if (fire) cnt_d = cnt_q + 5'd1;
    if (done) active_d = 1'b0;
    if (pop_o) begin
      active_d = 1'b1;
      cnt_d = '0;
      job_d = q_job_i;
    end
    out_valid_d = fire ? 1'b1 : (beat_o.ready ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      cnt_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      active_q <= active_d;
      cnt_q <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
    if (fire) begin
      bus_q <= bus;
      start_q <= (pos == '0);
      byte_q <= byte_val;
      end_q <= (pos == PosLast);
      last_q <= (cnt_q == last_idx);
    end
  end

  assign beat_o.valid = out_valid_q;
  assign beat_o.bus_select = bus_q;
  assign beat_o.frame_start = start_q;
  assign beat_o.frame_byte = byte_q;
  assign beat_o.frame_end = end_q;
  assign beat_o.last = last_q;

endmodule

`default_nettype wire

[hw/rtl/seven_segment_lcd_frame_builder.sv]
// seven-segment lcd frame builder
// item_i (sink) takes one command beat: a character, raw code, string, decimal,
// clear, blink change, refresh or init. beat_o (source) gives the frame bytes,
// one per beat, tagged with the bus, frame start, frame end and last-of-item.
// a refresh gives ten beats, init twenty (one frame on each bus); a refresh
// while the hold count runs gives nothing and counts the hold down.
// a first beat passes through the job queue, the back-end job register and the
// output register; a decimal is first converted, up to four digits, in the
// multiply-by-reciprocal stage. beats leave at one per cycle while the receiver
// is ready; the front accepts a new beat every cycle while the two-entry job
// queue has room, and stops only during decimal conversion.
// a stalled receiver holds the output register; the queue fills and then the
// input is held off. reset clears the codes, blink flag, hold count, queue
// and output register.
`default_nettype none
`include "seven_segment_lcd_frame_builder_macros.svh"

module seven_segment_lcd_frame_builder #(
  parameter int unsigned HOLD_CYCLES = 8
) (
  input wire logic   clk_i,
  input wire logic   rst_ni,
  ssl_item_if.sink   item_i,
  ssl_beat_if.source beat_o
);

  logic                   push;
  ssl_pkg::job_t          push_job;
  logic                   pop;
  ssl_pkg::job_t          q_job;
  ssl_pkg::queue_status_t q_status;

  ssl_front #(
    .HOLD_CYCLES(HOLD_CYCLES)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .item_i    (item_i),
    .q_status_i(q_status),
    .push_o    (push),
    .push_job_o(push_job)
  );

  ssl_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_job_i(push_job),
    .pop_i     (pop),
    .pop_job_o (q_job),
    .status_o  (q_status)
  );

  ssl_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_status_i(q_status),
    .q_job_i   (q_job),
    .pop_o     (pop),
    .beat_o    (beat_o)
  );

  `SSL_ASSERT_IMP(a_ready_needs_room, clk_i, rst_ni, item_i.ready, !q_status.full)
  `SSL_ASSERT_NEXT(a_push_lands, clk_i, rst_ni, push, q_status.valid)
  `SSL_ASSERT_IMP(a_last_ends_frame, clk_i, rst_ni, beat_o.valid && beat_o.last, beat_o.frame_end)
  `SSL_ASSERT_IMP(a_start_not_end, clk_i, rst_ni, beat_o.valid && beat_o.frame_start, !beat_o.frame_end)

endmodule

`default_nettype wire

[dv/tb.sv]
`default_nettype none

module tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned HOLD = 8;
  localparam int unsigned RAND_CMDS = 195;
  localparam int unsigned IDLE_LIMIT = 2000;
  localparam int unsigned TAIL_CYCLES = 40;
  localparam logic [3:0] KIND_LAST_CODE = 4'hF;

  typedef struct packed {
    logic               drain_first;
    logic [3:0]         kind;
    logic [1:0]         position;
    logic [3:0][7:0]    chars;
    logic signed [15:0] dec_value;
    logic               timed;
    logic               bus;
  } lcd_cmd_t;

  typedef struct packed {
    logic       bus;
    logic       start;
    logic [7:0] data;
    logic       fin;
    logic       last;
  } frame_beat_t;

  logic clk_i;
  logic rst_ni;

  ssl_item_if item_bus ();
  ssl_beat_if beat_bus ();

  seven_segment_lcd_frame_builder #(
    .HOLD_CYCLES(HOLD)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .item_i(item_bus),
    .beat_o(beat_bus)
  );

  lcd_cmd_t    cmd_queue[$];
  frame_beat_t frame_beats_due[$];

  logic [3:0][7:0] shadow_codes;
  logic            shadow_blink;
  logic [3:0]      shadow_hold;

  int unsigned fail_count;
  int unsigned idle_cycles;
  bit          cmd_taken;
  bit          cmd_held;
  int unsigned burst_left;
  int unsigned gap_left;
  int unsigned ready_phase_left;
  int unsigned ready_mode;
  int unsigned ready_tick;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  task automatic report(input string what, input int got, input int want);
    $display("mismatch %s: got %0h, want %0h", what, got, want);
    fail_count++;
  endtask

  function automatic logic [7:0] glyph(input logic [7:0] c);
    if (c >= "a" && c <= "z") begin
      return ssl_pkg::FONT_ROM[int'(ssl_pkg::FONT_LETTER_A) + int'(c - "a")];
    end
    if (c >= "A" && c <= "Z") begin
      return ssl_pkg::FONT_ROM[int'(ssl_pkg::FONT_LETTER_A) + int'(c - "A")];
    end
    if (c >= "0" && c <= "9") begin
      return ssl_pkg::FONT_ROM[int'(ssl_pkg::FONT_DIGIT0) + int'(c - "0")];
    end
    if (c == "-") return ssl_pkg::FONT_ROM[ssl_pkg::FONT_DASH];
    if (c == "_") return ssl_pkg::FONT_ROM[ssl_pkg::FONT_UNDERSCORE];
    if (c == "*") return ssl_pkg::FONT_ROM[ssl_pkg::FONT_DEGREE];
    return ssl_pkg::FONT_ROM[ssl_pkg::FONT_BLANK];
  endfunction

  task automatic push_frame(input logic bus, input logic [7:0] f [ssl_pkg::FRAME_LEN]);
    frame_beat_t b;
    for (int i = 0; i < ssl_pkg::FRAME_LEN; i++) begin
      b.bus = bus;
      b.start = (i == 0);
      b.data = f[i];
      b.fin = (i == ssl_pkg::FRAME_LEN - 1);
      b.last = 1'b0;
      frame_beats_due.push_back(b);
    end
  endtask

  task automatic refresh_display(input logic bus);
    logic [7:0] f [ssl_pkg::FRAME_LEN];
    if (shadow_hold != 0) begin
      shadow_hold = shadow_hold - 4'd1;
    end else begin
      f[0] = ssl_pkg::CMD_MODE;
      f[1] = ssl_pkg::CMD_POINTER;
      f[2] = ssl_pkg::CMD_DEVICE;
      f[3] = ssl_pkg::CMD_BANK;
      f[4] = shadow_blink ? ssl_pkg::CMD_FLASH : ssl_pkg::CMD_NO_BLINK;
      f[5] = shadow_codes[0] >> 4;
      f[6] = (shadow_codes[0] << 4) | (shadow_codes[1] >> 3);
      f[7] = (shadow_codes[1] << 5) | (shadow_codes[2] >> 2);
      f[8] = (shadow_codes[2] << 6) | (shadow_codes[3] >> 1);
      f[9] = shadow_codes[3] << 7;
      push_frame(bus, f);
    end
  endtask

  task automatic show_decimal(input logic signed [15:0] raw);
    int v;
    int mag;
    int p;
    logic neg;
    v = int'(raw);
    if (v < -int'(ssl_pkg::DEC_MIN_MAG)) v = -int'(ssl_pkg::DEC_MIN_MAG);
    if (v > int'(ssl_pkg::DEC_MAX)) v = int'(ssl_pkg::DEC_MAX);
    neg = (v < 0);
    mag = neg ? -v : v;
    shadow_codes = '0;
    p = 3;
    do begin
      shadow_codes[p] = ssl_pkg::FONT_ROM[mag % 10];
      mag = mag / 10;
      p--;
    end while (mag != 0 && p >= 0);
    if (neg && p >= 0) shadow_codes[p] = ssl_pkg::FONT_ROM[ssl_pkg::FONT_DASH];
  endtask

  task automatic predict_frames(input lcd_cmd_t c);
    int unsigned due_before;
    logic [7:0] f [ssl_pkg::FRAME_LEN];
    due_before = frame_beats_due.size();
    case (c.kind)
      ssl_pkg::KIND_CHAR: begin
        shadow_codes[c.position] = glyph(c.chars[0]);
        refresh_display(c.bus);
      end
      ssl_pkg::KIND_RAW: begin
        shadow_codes[c.position] = c.chars[0];
        refresh_display(c.bus);
      end
      ssl_pkg::KIND_STRING: begin
        shadow_codes = '0;
        for (int i = 0; i < ssl_pkg::NUM_DIGITS; i++) begin
          if (c.chars[i] == 8'h00) break;
          shadow_codes[i] = glyph(c.chars[i]);
        end
        refresh_display(c.bus);
        if (c.timed) shadow_hold = 4'(HOLD);
      end
      ssl_pkg::KIND_DECIMAL: begin
        show_decimal(c.dec_value);
        refresh_display(c.bus);
      end
      ssl_pkg::KIND_CLEAR: begin
        shadow_codes = '0;
        refresh_display(c.bus);
      end
      ssl_pkg::KIND_BLINK_OFF: begin
        shadow_blink = 1'b0;
        refresh_display(c.bus);
      end
      ssl_pkg::KIND_BLINK_ON: begin
        shadow_blink = 1'b1;
        refresh_display(c.bus);
      end
      ssl_pkg::KIND_REFRESH: begin
        refresh_display(c.bus);
      end
      ssl_pkg::KIND_INIT: begin
        shadow_blink = 1'b0;
        shadow_codes = '0;
        shadow_hold = '0;
        for (int i = 0; i < ssl_pkg::FRAME_LEN; i++) f[i] = ssl_pkg::INIT_FRAME[i];
        push_frame(1'b0, f);
        push_frame(1'b1, f);
      end
      default: begin
      end
    endcase
    if (frame_beats_due.size() > due_before) frame_beats_due[$].last = 1'b1;
  endtask

  function automatic lcd_cmd_t cmd(input logic [3:0] kind, input logic [1:0] pos,
                                   input logic [7:0] c0, input logic [7:0] c1,
                                   input logic [7:0] c2, input logic [7:0] c3,
                                   input logic signed [15:0] dec, input logic timed,
                                   input logic bus);
    lcd_cmd_t c;
    c.drain_first = 1'b0;
    c.kind = kind;
    c.position = pos;
    c.chars = {c3, c2, c1, c0};
    c.dec_value = dec;
    c.timed = timed;
    c.bus = bus;
    return c;
  endfunction

  function automatic logic [7:0] rand_char();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 25) return 8'("a" + $urandom_range(0, 25));
    if (r < 45) return 8'("A" + $urandom_range(0, 25));
    if (r < 65) return 8'("0" + $urandom_range(0, 9));
    if (r < 72) return "-";
    if (r < 78) return "_";
    if (r < 84) return "*";
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic lcd_cmd_t rand_cmd();
    lcd_cmd_t c;
    int unsigned r;
    c.drain_first = 1'b0;
    c.position = 2'($urandom_range(0, 3));
    for (int i = 0; i < ssl_pkg::NUM_DIGITS; i++) c.chars[i] = rand_char();
    r = $urandom_range(0, 99);
    if (r < 50) c.dec_value = 16'(int'($urandom_range(0, 10998)) - 999);
    else if (r < 70) c.dec_value = 16'(int'($urandom_range(0, 40)) - 1020);
    else if (r < 80) c.dec_value = 16'(int'($urandom_range(9980, 10020)));
    else c.dec_value = 16'($urandom_range(0, 16'hFFFF));
    c.timed = 1'($urandom_range(0, 1));
    c.bus = 1'($urandom_range(0, 1));
    r = $urandom_range(0, 99);
    if (r < 12) c.kind = ssl_pkg::KIND_CHAR;
    else if (r < 22) c.kind = ssl_pkg::KIND_RAW;
    else if (r < 40) c.kind = ssl_pkg::KIND_STRING;
    else if (r < 58) c.kind = ssl_pkg::KIND_DECIMAL;
    else if (r < 63) c.kind = ssl_pkg::KIND_CLEAR;
    else if (r < 68) c.kind = ssl_pkg::KIND_BLINK_OFF;
    else if (r < 74) c.kind = ssl_pkg::KIND_BLINK_ON;
    else if (r < 88) c.kind = ssl_pkg::KIND_REFRESH;
    else if (r < 93) c.kind = ssl_pkg::KIND_INIT;
    else c.kind = 4'($urandom_range(int'(ssl_pkg::KIND_INIT) + 1, int'(KIND_LAST_CODE)));
    if (c.kind == ssl_pkg::KIND_RAW && $urandom_range(0, 3) == 0) begin
      c.chars[0] = 8'($urandom_range(0, 255));
    end
    if (c.kind == ssl_pkg::KIND_STRING) begin
      for (int i = 0; i < ssl_pkg::NUM_DIGITS; i++) begin
        if ($urandom_range(0, 99) < 15) c.chars[i] = 8'h00;
      end
      c.timed = ($urandom_range(0, 99) < 25);
    end
    return c;
  endfunction

  // sender: bursts with gaps, one beat held until taken
  always @(negedge clk_i) begin : feed_cmds
    lcd_cmd_t c;
    if (rst_ni) begin
      if (cmd_taken) begin
        cmd_taken = 1'b0;
        cmd_held = 1'b0;
      end
      if (!cmd_held) begin
        if (gap_left != 0) begin
          gap_left--;
          item_bus.valid <= 1'b0;
        end else if (cmd_queue.size() == 0 ||
                     (cmd_queue[0].drain_first && frame_beats_due.size() != 0)) begin
          item_bus.valid <= 1'b0;
        end else begin
          c = cmd_queue.pop_front();
          item_bus.kind <= c.kind;
          item_bus.position <= c.position;
          item_bus.char_first <= c.chars[0];
          item_bus.char_second <= c.chars[1];
          item_bus.char_third <= c.chars[2];
          item_bus.char_fourth <= c.chars[3];
          item_bus.dec_value <= c.dec_value;
          item_bus.timed <= c.timed;
          item_bus.display_select <= c.bus;
          item_bus.valid <= 1'b1;
          cmd_held = 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = ($urandom_range(0, 9) == 0) ? 40 : $urandom_range(1, 12);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
          end
        end
      end
    end
  end

  // receiver: stall pattern changes from one random-length phase to the next
  always @(negedge clk_i) begin : pace_ready
    if (ready_phase_left == 0) begin
      ready_mode = $urandom_range(0, 4);
      ready_phase_left = $urandom_range(8, 60);
    end
    ready_phase_left--;
    ready_tick++;
    case (ready_mode)
      0: beat_bus.ready <= 1'b1;
      1: beat_bus.ready <= ($urandom_range(0, 3) != 0);
      2: beat_bus.ready <= 1'($urandom_range(0, 1));
      3: beat_bus.ready <= ((ready_tick % 7) < 4);
      default: beat_bus.ready <= (ready_phase_left < 4);
    endcase
  end

  always @(posedge clk_i) begin : observe
    frame_beat_t got;
    frame_beat_t want;
    lcd_cmd_t seen;
    if (rst_ni) begin
      if (beat_bus.valid && beat_bus.ready) begin
        got.bus = beat_bus.bus_select;
        got.start = beat_bus.frame_start;
        got.data = beat_bus.frame_byte;
        got.fin = beat_bus.frame_end;
        got.last = beat_bus.last;
        if (frame_beats_due.size() == 0) begin
          report("beat with nothing due, byte", got.data, 0);
        end else begin
          want = frame_beats_due.pop_front();
          if (got.bus != want.bus) report("bus_select", got.bus, want.bus);
          if (got.start != want.start) report("frame_start", got.start, want.start);
          if (got.data != want.data) report("frame_byte", got.data, want.data);
          if (got.fin != want.fin) report("frame_end", got.fin, want.fin);
          if (got.last != want.last) report("last", got.last, want.last);
        end
      end
      if (item_bus.valid && item_bus.ready) begin
        seen.drain_first = 1'b0;
        seen.kind = item_bus.kind;
        seen.position = item_bus.position;
        seen.chars = {item_bus.char_fourth, item_bus.char_third,
                      item_bus.char_second, item_bus.char_first};
        seen.dec_value = item_bus.dec_value;
        seen.timed = item_bus.timed;
        seen.bus = item_bus.display_select;
        predict_frames(seen);
        cmd_taken = 1'b1;
      end
      if ((item_bus.valid && item_bus.ready) || (beat_bus.valid && beat_bus.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
  end

  initial begin
    lcd_cmd_t c;
    int unsigned counted;
    bit timed_out;

    rst_ni = 1'b0;
    item_bus.valid = 1'b0;
    item_bus.kind = ssl_pkg::KIND_CHAR;
    item_bus.position = '0;
    item_bus.char_first = '0;
    item_bus.char_second = '0;
    item_bus.char_third = '0;
    item_bus.char_fourth = '0;
    item_bus.dec_value = '0;
    item_bus.timed = 1'b0;
    item_bus.display_select = 1'b0;
    beat_bus.ready = 1'b0;
    shadow_codes = '0;
    shadow_blink = 1'b0;
    shadow_hold = '0;
    fail_count = 0;
    idle_cycles = 0;
    cmd_taken = 1'b0;
    cmd_held = 1'b0;
    burst_left = 4;
    gap_left = 0;
    ready_phase_left = 0;
    ready_mode = 0;
    ready_tick = 0;
    timed_out = 1'b0;

    cmd_queue.push_back(cmd(ssl_pkg::KIND_INIT, 2'd0, 8'h00, 8'h00, 8'h00, 8'h00, 16'sd0,
                            1'b0, 1'b1));
    cmd_queue.push_back(cmd(ssl_pkg::KIND_CHAR, 2'd0, "a", 8'hFF, 8'h00, 8'h00, 16'sd0,
                            1'b1, 1'b0));
    cmd_queue.push_back(cmd(ssl_pkg::KIND_CHAR, 2'd1, "Z", 8'h00, 8'hFF, 8'h00, 16'sd0,
                            1'b0, 1'b1));
    cmd_queue.push_back(cmd(ssl_pkg::KIND_CHAR, 2'd2, "*", 8'h00, 8'h00, 8'hFF, 16'sd0,
                            1'b0, 1'b0));
    cmd_queue.push_back(cmd(ssl_pkg::KIND_CHAR, 2'd3, "_", 8'h00, 8'h00, 8'h00, 16'sd0,
                            1'b0, 1'b1));
    cmd_queue.push_back(cmd(ssl_pkg::KIND_CHAR, 2'd1, 8'hFF, 8'h00, 8'h00, 8'h00, 16'sd0,
                            1'b0, 1'b0));
    cmd_queue.push_back(cmd(ssl_pkg::KIND_RAW, 2'd3, 8'hFF, 8'h00, 8'h00, 8'h00, 16'sd0,
                            1'b0, 1'b0));
    cmd_queue.push_back(cmd(ssl_pkg::KIND_RAW, 2'd0, 8'h80, 8'h00, 8'h00, 8'h00, 16'sd0,
                            1'b0, 1'b1));
    cmd_queue.push_back(cmd(ssl_pkg::KIND_BLINK_ON, 2'd0, 8'h00, 8'h00, 8'h00, 8'h00, 16'sd0,
                            1'b0, 1'b0));
    cmd_queue.push_back(cmd(ssl_pkg::KIND_STRING, 2'd0, "-", "0", "9", "z", 16'sd0,
                            1'b0, 1'b1));
    cmd_queue.push_back(cmd(ssl_pkg::KIND_DECIMAL, 2'd0, 8'h00, 8'h00, 8'h00, 8'h00,
                            -16'sd32768, 1'b0, 1'b0));
    cmd_queue.push_back(cmd(ssl_pkg::KIND_DECIMAL, 2'd0, 8'h00, 8'h00, 8'h00, 8'h00,
                            16'sd32767, 1'b0, 1'b1));
    cmd_queue.push_back(cmd(ssl_pkg::KIND_DECIMAL, 2'd0, 8'h00, 8'h00, 8'h00, 8'h00,
                            -16'sd9, 1'b0, 1'b0));
    cmd_queue.push_back(cmd(ssl_pkg::KIND_DECIMAL, 2'd0, 8'h00, 8'h00, 8'h00, 8'h00,
                            16'sd0, 1'b0, 1'b1));
    cmd_queue.push_back(cmd(ssl_pkg::KIND_STRING, 2'd0, "A", 8'h00, "B", "C", 16'sd0,
                            1'b1, 1'b0));
    cmd_queue.push_back(cmd(ssl_pkg::KIND_REFRESH, 2'd0, 8'h00, 8'h00, 8'h00, 8'h00, 16'sd0,
                            1'b0, 1'b1));
    cmd_queue.push_back(cmd(KIND_LAST_CODE, 2'd3, 8'hFF, 8'hFF, 8'hFF, 8'hFF, -16'sd1, 1'b1,
                            1'b1));
    // timed string blanks then holds; init must clear the hold
    cmd_queue.push_back(cmd(ssl_pkg::KIND_STRING, 2'd0, "8", "8", "8", "8", 16'sd0,
                            1'b1, 1'b1));
    cmd_queue.push_back(cmd(ssl_pkg::KIND_INIT, 2'd0, 8'h00, 8'h00, 8'h00, 8'h00, 16'sd0,
                            1'b1, 1'b0));
    cmd_queue.push_back(cmd(ssl_pkg::KIND_STRING, 2'd0, 8'h00, "1", "2", "3", 16'sd0,
                            1'b1, 1'b0));
    cmd_queue.push_back(cmd(ssl_pkg::KIND_DECIMAL, 2'd0, 8'h00, 8'h00, 8'h00, 8'h00,
                            16'sd1234, 1'b0, 1'b1));
    cmd_queue.push_back(cmd(4'(int'(ssl_pkg::KIND_INIT) + 1), 2'd0, 8'h00, 8'h00, 8'h00,
                            8'h00, 16'sd0, 1'b0, 1'b0));
    cmd_queue.push_back(cmd(ssl_pkg::KIND_BLINK_OFF, 2'd0, 8'h00, 8'h00, 8'h00, 8'h00,
                            16'sd0, 1'b0, 1'b1));
    cmd_queue.push_back(cmd(ssl_pkg::KIND_CLEAR, 2'd0, 8'h00, 8'h00, 8'h00, 8'h00, 16'sd0,
                            1'b0, 1'b0));
    cmd_queue.push_back(cmd(ssl_pkg::KIND_DECIMAL, 2'd0, 8'h00, 8'h00, 8'h00, 8'h00,
                            -16'sd1000, 1'b0, 1'b1));
    cmd_queue[$].drain_first = 1'b1;

    counted = 0;
    while (counted < RAND_CMDS) begin
      c = rand_cmd();
      if ($urandom_range(0, 49) == 0) c.drain_first = 1'b1;
      cmd_queue.push_back(c);
      counted++;
    end

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    fork
      begin
        wait (cmd_queue.size() == 0 && !cmd_held);
        wait (frame_beats_due.size() == 0);
        repeat (TAIL_CYCLES) @(posedge clk_i);
      end
      begin
        wait (idle_cycles >= IDLE_LIMIT);
        timed_out = 1'b1;
      end
    join_any

    if (timed_out || fail_count != 0 || frame_beats_due.size() != 0) begin
      $display("*** FAILED ***");
    end else begin
      $display("*** PASSED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire

[sim.f]
+incdir+hw/rtl
hw/rtl/ssl_pkg.sv
hw/rtl/ssl_if.sv
hw/rtl/ssl_front.sv
hw/rtl/ssl_queue.sv
hw/rtl/ssl_back.sv
hw/rtl/seven_segment_lcd_frame_builder.sv
dv/tb.sv
